[rtl/core/rcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants of the register cache with pinned slots.
// ----------------------------------------------------------------------------
package rcl_pkg;

  localparam int REG_W      = 5;
  localparam int FUNC_W     = 2;
  localparam int SLOT_OUT_W = 3;
  localparam int STAMP_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_PINNED = 4;
  localparam int PIN_CNT_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_INVAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PINNED_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PINNED_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PINNED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PINNED_3 = 2'd3;

  localparam logic [REG_W-1:0] PIN_RESET [MAX_PINNED] = '{5'd10, 5'd11, 5'd12, 5'd13};

  typedef enum logic [2:0] {
    ACT_GRANT = 3'd0,
    ACT_WB    = 3'd1,
    ACT_FILL  = 3'd2,
    ACT_ZERO  = 3'd3,
    ACT_DONE  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CMD_ZERO,
    CMD_READ,
    CMD_WRITE,
    CMD_FLUSH,
    CMD_INVAL
  } cmd_kind_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ZERO,
    B_LOOK,
    B_SCAN,
    B_MISS,
    B_FILL,
    B_GRANT,
    B_FLUSH,
    B_PIN,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REG_W-1:0]  reg_num;
  } in_t;

  typedef struct packed {
    action_e               action;
    logic [REG_W-1:0]      target_reg;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  last;
  } out_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [REG_W-1:0] greg;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     data;
  } cfg_wr_t;

endpackage

[rtl/core/rcl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_front
// Input stage: takes request words, decodes them into commands and holds
// one command until the command queue takes it.
// ----------------------------------------------------------------------------
module rcl_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  rcl_pkg::in_t in_data_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output rcl_pkg::cmd_t cmd_o
);
  import rcl_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d.greg = in_data_i.reg_num;
    case (in_data_i.func)
      FUNC_READ:  cmd_d.kind = (in_data_i.reg_num == '0) ? CMD_ZERO : CMD_READ;
      FUNC_WRITE: cmd_d.kind = (in_data_i.reg_num == '0) ? CMD_ZERO : CMD_WRITE;
      FUNC_FLUSH: cmd_d.kind = CMD_FLUSH;
      FUNC_INVAL: cmd_d.kind = CMD_INVAL;
      default:    cmd_d.kind = CMD_INVAL;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/core/rcl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_queue
// Two-entry command queue between the decode stage and the sequencer.
// ----------------------------------------------------------------------------
module rcl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  rcl_pkg::cmd_t data_i,
  output logic          valid_o,
  input  logic          pop_i,
  output rcl_pkg::cmd_t data_o
);
  import rcl_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/rcl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_back
// Sequencer: holds the slot table and pinned registers, runs lookups,
// victim scans, flushes and reloads, and drives the registered result port.
// ----------------------------------------------------------------------------
module rcl_back #(
  parameter int NUM_SLOTS  = 8,
  parameter int NUM_PINNED = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcl_pkg::cfg_wr_t cfg_i,
  input  logic             cmd_valid_i,
  input  rcl_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rcl_pkg::out_t    out_data_o
);
  import rcl_pkg::*;

  localparam int SlotW   = $clog2(NUM_SLOTS);
  localparam int PinBase = NUM_SLOTS - NUM_PINNED;

  // slot table
  logic [REG_W-1:0]   slot_reg_q   [NUM_SLOTS];
  logic               slot_valid_q [NUM_SLOTS];
  logic               slot_dirty_q [NUM_SLOTS];
  logic [STAMP_W-1:0] slot_stamp_q [NUM_SLOTS];
  logic [STAMP_W-1:0] use_cnt_q;
  logic [REG_W-1:0]   pin_cfg_q    [MAX_PINNED];

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [SlotW-1:0]   scan_q, scan_d;
  logic [SlotW-1:0]   best_q, best_d;
  logic [STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic [PIN_CNT_W-1:0] pin_q, pin_d;
  logic               miss_q, miss_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               emit_ok;
  logic               do_grant;
  logic               do_inval;
  logic               hit;
  logic [SlotW-1:0]   hit_idx;
  logic               free;
  logic [SlotW-1:0]   free_idx;
  logic               take;
  logic [SlotW-1:0]   best_nxt;
  logic               cur_wb;
  logic [STAMP_W-1:0] use_cnt_inc;

  assign emit_ok     = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign use_cnt_inc = use_cnt_q + 1'b1;
  assign cur_wb      = slot_valid_q[idx_q] && slot_dirty_q[idx_q];

  // parallel tag match and first free unpinned slot, lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!hit && slot_valid_q[i] && slot_reg_q[i] == cmd_q.greg) begin
        hit     = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (!free && i < PinBase && !slot_valid_q[i]) begin
        free     = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // oldest-stamp scan over unpinned slots, one slot per cycle
  assign take     = (scan_q == '0) || (slot_stamp_q[scan_q] < best_stamp_q);
  assign best_nxt = take ? scan_q : best_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    scan_d       = scan_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    pin_d        = pin_q;
    miss_d       = miss_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    cmd_pop_o    = 1'b0;
    do_grant     = 1'b0;
    do_inval     = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.kind)
            CMD_ZERO:  state_d = B_ZERO;
            CMD_READ,
            CMD_WRITE: state_d = B_LOOK;
            CMD_FLUSH: begin
              idx_d   = '0;
              state_d = B_FLUSH;
            end
            CMD_INVAL: begin
              do_inval = 1'b1;
              pin_d    = '0;
              state_d  = B_PIN;
            end
            default:   state_d = B_IDLE;
          endcase
        end
      end
      B_ZERO: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{ACT_ZERO, '0, '0, 1'b1};
          state_d     = B_IDLE;
        end
      end
      B_LOOK: begin
        if (hit) begin
          idx_d   = hit_idx;
          miss_d  = 1'b0;
          state_d = B_GRANT;
        end else if (free) begin
          idx_d   = free_idx;
          miss_d  = 1'b1;
          state_d = B_MISS;
        end else begin
          scan_d  = '0;
          miss_d  = 1'b1;
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        best_d       = best_nxt;
        best_stamp_d = take ? slot_stamp_q[scan_q] : best_stamp_q;
        if (scan_q == SlotW'(PinBase - 1)) begin
          idx_d   = best_nxt;
          state_d = B_MISS;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      B_MISS: begin
        if (!cur_wb || emit_ok) begin
          if (cur_wb) begin
            out_valid_d = 1'b1;
            out_d       = '{ACT_WB, slot_reg_q[idx_q], SLOT_OUT_W'(idx_q), 1'b0};
          end
          state_d = (cmd_q.kind == CMD_READ) ? B_FILL : B_GRANT;
        end
      end
      B_FILL: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{ACT_FILL, cmd_q.greg, SLOT_OUT_W'(idx_q), 1'b0};
          state_d     = B_GRANT;
        end
      end
      B_GRANT: begin
        if (emit_ok) begin
          do_grant    = 1'b1;
          out_valid_d = 1'b1;
          out_d       = '{ACT_GRANT, cmd_q.greg, SLOT_OUT_W'(idx_q), 1'b1};
          state_d     = B_IDLE;
        end
      end
      B_FLUSH: begin
        if (!cur_wb || emit_ok) begin
          if (cur_wb) begin
            out_valid_d = 1'b1;
            out_d       = '{ACT_WB, slot_reg_q[idx_q], SLOT_OUT_W'(idx_q), 1'b0};
          end
          if (idx_q == SlotW'(NUM_SLOTS - 1)) begin
            state_d = B_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      B_PIN: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{ACT_FILL, pin_cfg_q[pin_q],
                          SLOT_OUT_W'(SlotW'(PinBase) + SlotW'(pin_q)), 1'b0};
          if (pin_q == PIN_CNT_W'(NUM_PINNED - 1)) begin
            state_d = B_DONE;
          end else begin
            pin_d = pin_q + 1'b1;
          end
        end
      end
      B_DONE: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{ACT_DONE, '0, '0, 1'b1};
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    scan_q       <= scan_d;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
    pin_q        <= pin_d;
    miss_q       <= miss_d;
    out_q        <= out_d;
  end

  // pinned register config, takes effect at the next reload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MAX_PINNED; p++) begin
        pin_cfg_q[p] <= PIN_RESET[p];
      end
    end else if (cfg_i.we) begin
      pin_cfg_q[cfg_i.idx] <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_cnt_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_reg_q[i]   <= (i >= PinBase) ? PIN_RESET[PIN_CNT_W'(i - PinBase)] : '0;
        slot_valid_q[i] <= (i >= PinBase);
        slot_dirty_q[i] <= 1'b0;
        slot_stamp_q[i] <= '0;
      end
    end else if (do_inval) begin
      use_cnt_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_reg_q[i]   <= (i >= PinBase) ? pin_cfg_q[PIN_CNT_W'(i - PinBase)] : '0;
        slot_valid_q[i] <= (i >= PinBase);
        slot_dirty_q[i] <= 1'b0;
        slot_stamp_q[i] <= '0;
      end
    end else if (do_grant) begin
      use_cnt_q           <= use_cnt_inc;
      slot_stamp_q[idx_q] <= use_cnt_inc;
      if (miss_q) begin
        slot_reg_q[idx_q]   <= cmd_q.greg;
        slot_valid_q[idx_q] <= 1'b1;
        slot_dirty_q[idx_q] <= (cmd_q.kind == CMD_WRITE);
      end else if (cmd_q.kind == CMD_WRITE) begin
        slot_dirty_q[idx_q] <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/register_cache_lru_pinned_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_cache_lru_pinned_core
// Fully associative LRU register cache with pinned slots: decode stage,
// two-entry command queue and slot-table sequencer with a result register.
// ----------------------------------------------------------------------------
// sequence: the zero register gets a zero word; a hit grants; a miss writes back a dirty victim,
//   fills on a read, then grants, with a stamp scan over the NUM_SLOTS-NUM_PINNED unpinned slots when none is free
// sequencer: takes no new command until the last result word of the current one is registered;
//   a flush writes back every dirty slot, an invalidate reloads the pinned slots
// reset: asynchronous; pinned slots hold registers 10..13, all clean, counter zero
module register_cache_lru_pinned_core #(
  parameter int NUM_SLOTS  = 8,
  parameter int NUM_PINNED = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcl_pkg::REG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rcl_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rcl_pkg::out_t                      out_data_o
);
  import rcl_pkg::*;

  cmd_t    fr_cmd, q_cmd;
  logic    fr_valid, q_ready, q_valid, q_pop;
  cfg_wr_t cfg;

  assign cfg = '{cfg_we_i, cfg_idx_i, cfg_data_i};

  rcl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (q_ready),
    .cmd_o       (fr_cmd)
  );

  rcl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .ready_o (q_ready),
    .data_i  (fr_cmd),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  rcl_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_PINNED (NUM_PINNED)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/rcl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_checker
// Port-level checks on the result channel of the register cache.
// ----------------------------------------------------------------------------
module rcl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rcl_pkg::out_t out_data_o
);
  import rcl_pkg::*;

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // grant, zero and done close an item, writeback and fill never do
  a_last_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last == (out_data_o.action == ACT_GRANT ||
                                        out_data_o.action == ACT_ZERO ||
                                        out_data_o.action == ACT_DONE))
    else $error("last flag does not match action");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_ZERO || out_data_o.action == ACT_DONE)
      |-> out_data_o.target_reg == '0 && out_data_o.slot_index == '0)
    else $error("zero or done word carries a register or slot");

  // a grant is never for guest register zero
  a_grant_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action == ACT_GRANT |-> out_data_o.target_reg != '0)
    else $error("grant issued for register zero");

endmodule

bind register_cache_lru_pinned_core rcl_checker u_rcl_checker (.*);
